// ----- design/lccl_pkg.sv -----
`timescale 1ns / 1ps

package lccl_pkg;

  // Number of worker lanes (1..16)
  localparam int LANES = 4;

  localparam int OPCODE_W    = 2;
  localparam int LANE_W      = 4;
  localparam int COORD_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int CLAIM_CNT_W = 3;
  localparam int COLL_W      = 32;

  // Slot index width; one bit minimum so a single-lane table still indexes
  localparam int SLOT_IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
  // Width wide enough to hold LANES itself for the bad-lane compare
  localparam int LANE_CMP_W  = LANE_W + 1;
  // Width of the raw popcount over all slots
  localparam int POP_W       = $clog2(LANES + 1);

  localparam logic [CLAIM_CNT_W-1:0] CLAIM_CNT_MAX = {CLAIM_CNT_W{1'b1}};
  localparam logic [COLL_W-1:0]      COLL_MAX      = {COLL_W{1'b1}};

  typedef enum logic [OPCODE_W-1:0] {
    OP_TAKE  = 2'd0,
    OP_DROP  = 2'd1,
    OP_PROBE = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LANE  = 2'd1,
    ST_BUSY      = 2'd2,
    ST_COLLISION = 2'd3
  } status_t;

endpackage

// ----- design/lane_column_claim_table.sv -----
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in_      in_valid/in_stall    in_opcode, in_lane, in_col_x, in_col_z
// out_     out_valid/out_stall  out_status .. out_collision_total (six fields)
//
// One item per cycle sustained while out_stall is low; an input transfer fills the
// input register, and lookup, slot update and result are formed combinationally from
// it into the result register; state changes at that move.
// rst_n is synchronous: clears slot valid bits, collision counter and both valids.
// out_stall holds the result register and backs up into the input register;
// in_stall rises only when both are full and out_stall is high.

module lane_column_claim_table (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lccl_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [lccl_pkg::LANE_W-1:0]        in_lane,
  input  logic signed [lccl_pkg::COORD_W-1:0] in_col_x,
  input  logic signed [lccl_pkg::COORD_W-1:0] in_col_z,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lccl_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_granted,
  output logic                               out_coord_held,
  output logic                               out_lane_busy,
  output logic [lccl_pkg::CLAIM_CNT_W-1:0]   out_claim_count,
  output logic [lccl_pkg::COLL_W-1:0]        out_collision_total
);

  localparam int LANES = lccl_pkg::LANES;

  // input register
  logic                                s1_valid_r;
  logic [lccl_pkg::OPCODE_W-1:0]       s1_opcode_r;
  logic [lccl_pkg::LANE_W-1:0]         s1_lane_r;
  logic [lccl_pkg::COORD_W-1:0]        s1_x_r;
  logic [lccl_pkg::COORD_W-1:0]        s1_z_r;

  // table state
  logic [LANES-1:0]                    slot_valid_r;
  logic [LANES-1:0]                    slot_valid_nxt;
  logic [lccl_pkg::COORD_W-1:0]        slot_x_r [LANES];
  logic [lccl_pkg::COORD_W-1:0]        slot_z_r [LANES];
  logic [lccl_pkg::COLL_W-1:0]         coll_cnt_r;
  logic [lccl_pkg::COLL_W-1:0]         coll_cnt_nxt;

  // result register
  logic                                out_valid_r;
  lccl_pkg::status_t                   status_r;
  logic                                granted_r;
  logic                                held_r;
  logic                                busy_r;
  logic [lccl_pkg::CLAIM_CNT_W-1:0]    count_r;
  logic [lccl_pkg::COLL_W-1:0]         coll_out_r;

  logic                                s2_ready;
  logic                                fire;
  logic                                in_xfer;

  lccl_pkg::opcode_t                   op;
  logic                                lane_good;
  logic [lccl_pkg::SLOT_IDX_W-1:0]     idx;
  logic [LANES-1:0]                    lane_1h;
  logic [LANES-1:0]                    match_pre;
  logic [LANES-1:0]                    match_post;
  logic                                held_pre;
  logic                                lane_valid;
  lccl_pkg::status_t                   status_c;
  logic                                grant_c;
  logic                                drop_c;
  logic                                collide_c;
  logic [lccl_pkg::POP_W-1:0]          pop_c;
  logic [lccl_pkg::CLAIM_CNT_W-1:0]    count_c;

  assign s2_ready = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_opcode_r <= in_opcode;
      s1_lane_r   <= in_lane;
      s1_x_r      <= in_col_x;
      s1_z_r      <= in_col_z;
    end
  end

  // lookup and decision
  always_comb begin
    op        = lccl_pkg::opcode_t'(s1_opcode_r);
    lane_good = ({1'b0, s1_lane_r} < lccl_pkg::LANE_CMP_W'(LANES));
    idx       = s1_lane_r[lccl_pkg::SLOT_IDX_W-1:0];
    lane_1h   = '0;
    if (lane_good) begin
      lane_1h[idx] = 1'b1;
    end
    for (int i = 0; i < LANES; i++) begin
      match_pre[i] = slot_valid_r[i] && (slot_x_r[i] == s1_x_r) &&
                     (slot_z_r[i] == s1_z_r);
    end
    held_pre   = |match_pre;
    lane_valid = |(slot_valid_r & lane_1h);

    status_c  = lccl_pkg::ST_OK;
    grant_c   = 1'b0;
    drop_c    = 1'b0;
    collide_c = 1'b0;
    if (!lane_good) begin
      status_c = lccl_pkg::ST_BAD_LANE;
    end else begin
      unique case (op)
        lccl_pkg::OP_TAKE: begin
          priority if (lane_valid) begin
            status_c = lccl_pkg::ST_BUSY;
          end else if (held_pre) begin
            status_c  = lccl_pkg::ST_COLLISION;
            collide_c = 1'b1;
          end else begin
            grant_c = 1'b1;
          end
        end
        lccl_pkg::OP_DROP: drop_c = 1'b1;
        default: ;
      endcase
    end

    slot_valid_nxt = slot_valid_r;
    if (grant_c) begin
      slot_valid_nxt = slot_valid_r | lane_1h;
    end else if (drop_c) begin
      slot_valid_nxt = slot_valid_r & ~lane_1h;
    end

    // a granted slot now holds this coordinate; a dropped one no longer does
    match_post = (match_pre & slot_valid_nxt) | (grant_c ? lane_1h : '0);

    coll_cnt_nxt = coll_cnt_r;
    if (collide_c && (coll_cnt_r != lccl_pkg::COLL_MAX)) begin
      coll_cnt_nxt = coll_cnt_r + 1'b1;
    end

    pop_c = '0;
    for (int i = 0; i < LANES; i++) begin
      pop_c = pop_c + lccl_pkg::POP_W'(slot_valid_nxt[i]);
    end
    if (32'(pop_c) > 32'(lccl_pkg::CLAIM_CNT_MAX)) begin
      count_c = lccl_pkg::CLAIM_CNT_MAX;
    end else begin
      count_c = lccl_pkg::CLAIM_CNT_W'(pop_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      coll_cnt_r   <= '0;
    end else if (fire) begin
      slot_valid_r <= slot_valid_nxt;
      coll_cnt_r   <= coll_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && grant_c) begin
      slot_x_r[idx] <= s1_x_r;
      slot_z_r[idx] <= s1_z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r   <= status_c;
      granted_r  <= grant_c;
      held_r     <= |match_post;
      busy_r     <= |(slot_valid_nxt & lane_1h);
      count_r    <= count_c;
      coll_out_r <= coll_cnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_granted         = granted_r;
  assign out_coord_held      = held_r;
  assign out_lane_busy       = busy_r;
  assign out_claim_count     = count_r;
  assign out_collision_total = coll_out_r;

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && granted_r |-> status_r == lccl_pkg::ST_OK && held_r && busy_r)
    else $error("granted take without ok status, held coordinate and busy lane");

  a_bad_lane_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == lccl_pkg::ST_BAD_LANE |-> !busy_r && !granted_r)
    else $error("bad lane reported busy or granted");

  a_coll_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> coll_cnt_r >= $past(coll_cnt_r))
    else $error("collision counter decreased");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(slot_valid_r) && $stable(coll_cnt_r))
    else $error("table state changed without a transfer into the result register");

  a_collision_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == lccl_pkg::ST_COLLISION |-> held_r && !granted_r)
    else $error("collision reported for a coordinate not held");

endmodule
